FILE: rtl/core/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// shared types, constants and the arctangent table for the vertex rotator
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int CordicStepsDef = 16;
  localparam int CordicMax      = 24;

  localparam logic signed [33:0] CordicK = 34'sh026DD3B6A;
  localparam logic signed [33:0] HalfPi  = 34'sd1686629713;
  localparam logic signed [33:0] Pi      = 34'sd3373259426;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_AXIS_X = 3'd1,
    REG_AXIS_Y = 3'd2,
    REG_AXIS_Z = 3'd3,
    REG_ANGLE = 3'd4,
    REG_SCALE = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    MB_IDLE,
    MB_CORDIC,
    MB_COEF
  } mb_state_t;

  typedef logic signed [15:0] coef_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/axis_angle_vertex_rotator.sv
// ----------------------------------------------------------------------------
// axis_angle_vertex_rotator
// streams q8.8 vertices through a rodrigues rotation matrix or a uniform scale
// ----------------------------------------------------------------------------
// One vertex per cycle through a four-stage pipeline (multiply, row sum,
// round/saturate, output register); the whole pipe holds, with in_stall high,
// while the output stalls. A write to an axis or the angle rebuilds the matrix
// (serial cordic, then one coefficient a cycle through a two-step multiply),
// with in_stall held high throughout, so every vertex after the write sees the
// finished matrix. Write configuration only while no vertex is in flight.
module axis_angle_vertex_rotator #(
  parameter int CORDIC_STEPS = aavr_pkg::CordicStepsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_vertex_x,
  input  logic signed [15:0] in_vertex_y,
  input  logic signed [15:0] in_vertex_z,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_out_x,
  output logic signed [15:0] out_out_y,
  output logic signed [15:0] out_out_z,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import aavr_pkg::*;

  logic mode_r;
  logic signed [15:0] ax_r, ay_r, az_r, ang_r, scale_r;
  logic rebuild;
  coef_t coef [9];
  logic adv;
  logic mat_busy;

  assign cfg_ready = 1'b1;
  assign rebuild = cfg_valid && (cfg_index == REG_AXIS_X || cfg_index == REG_AXIS_Y ||
                                 cfg_index == REG_AXIS_Z || cfg_index == REG_ANGLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0; ax_r <= '0; ay_r <= '0; az_r <= 16'sd16384;
      ang_r <= '0; scale_r <= 16'sd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_r  <= cfg_data[0];
        REG_AXIS_X: ax_r    <= cfg_data;
        REG_AXIS_Y: ay_r    <= cfg_data;
        REG_AXIS_Z: az_r    <= cfg_data;
        REG_ANGLE:  ang_r   <= cfg_data;
        REG_SCALE:  scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // builder sees the new value through a combinational bypass
  logic signed [15:0] bx, by, bz, ba;
  assign bx = (cfg_valid && cfg_index == REG_AXIS_X) ? cfg_data : ax_r;
  assign by = (cfg_valid && cfg_index == REG_AXIS_Y) ? cfg_data : ay_r;
  assign bz = (cfg_valid && cfg_index == REG_AXIS_Z) ? cfg_data : az_r;
  assign ba = (cfg_valid && cfg_index == REG_ANGLE) ? cfg_data : ang_r;

  aavr_matrix #(.CORDIC_STEPS(CORDIC_STEPS)) u_matrix (
    .clk(clk), .rst_n(rst_n), .start(rebuild),
    .axis_x(bx), .axis_y(by), .axis_z(bz), .angle(ba),
    .busy(mat_busy), .coef(coef)
  );

  // whole pipe advances together and holds as one while the output stalls
  logic v1_r, v2_r, v3_r;
  logic l1_r, l2_r, l3_r;
  logic m1_r, m2_r;
  logic signed [31:0] p_r [9];
  logic signed [33:0] s_r [3];
  logic signed [15:0] r_r [3];
  logic signed [33:0] rnd [3];
  logic signed [15:0] vin [3];

  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv || mat_busy;
  assign vin[0] = in_vertex_x;
  assign vin[1] = in_vertex_y;
  assign vin[2] = in_vertex_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (m2_r) rnd[k] = (s_r[k] + 34'sd128) >>> 8;
      else rnd[k] = (s_r[k] + 34'sd8192) >>> 14;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; out_valid <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid && !mat_busy; v2_r <= v1_r; v3_r <= v2_r; out_valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1_r <= in_last_in; m1_r <= mode_r;
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++)
          if (mode_r) p_r[k*3+j] <= (j == 0) ? 32'(vin[k]) * 32'(scale_r) : 32'sd0;
          else p_r[k*3+j] <= 32'(coef[k*3+j]) * 32'(vin[j]);
      l2_r <= l1_r; m2_r <= m1_r;
      for (int k = 0; k < 3; k++)
        s_r[k] <= 34'(p_r[k*3]) + 34'(p_r[k*3+1]) + 34'(p_r[k*3+2]);
      l3_r <= l2_r;
      for (int k = 0; k < 3; k++)
        if (rnd[k] > 34'sd32767) r_r[k] <= 16'sh7FFF;
        else if (rnd[k] < -34'sd32768) r_r[k] <= 16'sh8000;
        else r_r[k] <= 16'(rnd[k]);
      out_last_out <= l3_r;
      out_out_x <= r_r[0]; out_out_y <= r_r[1]; out_out_z <= r_r[2];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_out_x) && $stable(out_last_out)))
    else $error("output changed while stalled");
  a_nostall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid || mat_busy)) else $error("stall with empty output");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && v3_r) |=> out_valid) else $error("item lost in pipe");

endmodule

FILE: rtl/core/aavr_matrix.sv
// ----------------------------------------------------------------------------
// aavr_matrix
// iterative cordic for cos/sin, then builds the nine coefficients one a cycle
// ----------------------------------------------------------------------------
module aavr_matrix #(
  parameter int CORDIC_STEPS = aavr_pkg::CordicStepsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [15:0]  axis_x,
  input  logic signed [15:0]  axis_y,
  input  logic signed [15:0]  axis_z,
  input  logic signed [15:0]  angle,
  output logic                busy,
  output aavr_pkg::coef_t     coef [9]
);
  import aavr_pkg::*;

  localparam int Steps = (CORDIC_STEPS > CordicMax) ? CordicMax : CORDIC_STEPS;

  mb_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [1:0]  row_r, col_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic neg_r;
  logic signed [15:0] c_r, s_r;
  coef_t coef_r [9];
  logic signed [33:0] z0, x_fin, y_fin, dx, dy, xr, yr;
  logic signed [33:0] at;
  logic signed [17:0] cc, sc;
  logic signed [15:0] ar, ak, ao;
  logic signed [16:0] omc;
  logic signed [32:0] pa_nxt, pa_r;
  logic signed [31:0] sb_nxt, sb_r;
  logic signed [15:0] ak_r;
  logic               diag_r, minus_r, wv_r;
  logic [3:0]         widx_r;
  logic signed [48:0] v;
  logic signed [35:0] vq;

  assign z0 = 34'(angle) <<< 17;
  assign at = atan_q30(cnt_r);
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign x_fin = neg_r ? -x_r : x_r;
  assign y_fin = neg_r ? -y_r : y_r;
  assign xr = (x_fin + 34'sd32768) >>> 16;
  assign yr = (y_fin + 34'sd32768) >>> 16;

  always_comb begin
    cc = 18'(xr);
    sc = 18'(yr);
    if (cc > 18'sd16384) cc = 18'sd16384;
    if (cc < -18'sd16384) cc = -18'sd16384;
    if (sc > 18'sd16384) sc = 18'sd16384;
    if (sc < -18'sd16384) sc = -18'sd16384;
  end

  function automatic logic signed [15:0] pick(input logic [1:0] i, input logic signed [15:0] a0,
                                              input logic signed [15:0] a1,
                                              input logic signed [15:0] a2);
    logic signed [15:0] r;
    case (i)
      2'd0: r = a0;
      2'd1: r = a1;
      default: r = a2;
    endcase
    return r;
  endfunction

  // first step: (1-c)*ai and s*ao, registered with the column component
  always_comb begin
    ar = pick(row_r, axis_x, axis_y, axis_z);
    ak = pick(col_r, axis_x, axis_y, axis_z);
    ao = pick(2'(3 - int'(row_r) - int'(col_r)), axis_x, axis_y, axis_z);
    omc = 17'sd16384 - 17'(c_r);
    pa_nxt = 33'(omc) * 33'(ar);
    sb_nxt = 32'(s_r) * 32'(ao);
  end

  // second step: times ak, add the diagonal or cross term, round
  always_comb begin
    v = 49'(pa_r) * 49'(ak_r);
    if (diag_r) v = v + (49'(c_r) <<< 28);
    else if (minus_r) v = v - (49'(sb_r) <<< 14);
    else v = v + (49'(sb_r) <<< 14);
    vq = 36'((v + 49'sd134217728) >>> 28);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      MB_IDLE: begin
        if (start) begin
          state_nxt = MB_CORDIC;
          cnt_nxt   = '0;
        end
      end
      MB_CORDIC: begin
        if (cnt_r == 5'(Steps)) begin
          state_nxt = MB_COEF;
          idx_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      MB_COEF: begin
        if (idx_r == 4'd8) state_nxt = MB_IDLE;
        else idx_nxt = idx_r + 4'd1;
      end
      default: state_nxt = MB_IDLE;
    endcase
    if (start) begin
      state_nxt = MB_CORDIC;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MB_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      wv_r    <= 1'b0;
      for (int i = 0; i < 9; i++) coef_r[i] <= (i % 4 == 0) ? 16'sd16384 : 16'sd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      wv_r    <= (state_r == MB_COEF) && !start;
      if (wv_r && !start) begin
        if (vq > 36'sd32767) coef_r[widx_r] <= 16'sh7FFF;
        else if (vq < -36'sd32768) coef_r[widx_r] <= 16'sh8000;
        else coef_r[widx_r] <= 16'(vq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CordicK;
      y_r <= '0;
      neg_r <= (z0 > HalfPi) || (z0 < -HalfPi);
      if (z0 > HalfPi) z_r <= z0 - Pi;
      else if (z0 < -HalfPi) z_r <= z0 + Pi;
      else z_r <= z0;
    end else if (state_r == MB_CORDIC && cnt_r != 5'(Steps)) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + at;
      end
    end
    if (state_r == MB_CORDIC && cnt_r == 5'(Steps)) begin
      c_r <= 16'(cc);
      s_r <= 16'(sc);
      row_r <= '0;
      col_r <= '0;
    end else if (state_r == MB_COEF) begin
      if (col_r == 2'd2) begin
        col_r <= '0;
        row_r <= row_r + 2'd1;
      end else begin
        col_r <= col_r + 2'd1;
      end
    end
    pa_r    <= pa_nxt;
    sb_r    <= sb_nxt;
    ak_r    <= ak;
    diag_r  <= (row_r == col_r);
    minus_r <= (col_r == row_r + 2'd1) || (row_r == 2'd2 && col_r == 2'd0);
    widx_r  <= idx_r;
  end

  assign coef = coef_r;
  assign busy = (state_r != MB_IDLE) || wv_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MB_COEF) |-> (idx_r <= 4'd8)) else $error("coef index out of range");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MB_CORDIC) |-> (cnt_r <= 5'(Steps))) else $error("cordic count overrun");
  a_rowcol: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == MB_COEF && !$past(start)) |-> (row_r != 2'd3)) else $error("row overrun");
  a_widx: assert property (@(posedge clk) disable iff (!rst_n)
    wv_r |-> (widx_r <= 4'd8)) else $error("coef write index out of range");

endmodule

FILE: tb/axis_angle_vertex_rotator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_vertex_rotator_tb
// drives vertex items under random idling on both sides, predicts each result
// with a local rodrigues matrix and scale model, and compares every field
// ----------------------------------------------------------------------------
module axis_angle_vertex_rotator_tb;
  import aavr_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
  } vertex_t;

  localparam int MatrixSettle = 60;
  localparam longint CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_vertex_x = '0, in_vertex_y = '0, in_vertex_z = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_out_x, out_out_y, out_out_z;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  axis_angle_vertex_rotator uut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic             rot_mode;
  longint           ax [3];
  longint           rot_angle, scale_q88;
  longint           coef [9];

  vertex_t pending_vertices[$];
  vertex_t expected_vertices[$];
  int      send_idle_pct = 0, recv_idle_pct = 0;
  int      mismatches = 0;
  longint  cycles = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint arctan_step(int i);
    longint t [24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  task automatic rebuild_rotation;
    longint z, x, y, dx, dy, c, s, omc, v, t;
    bit flip;
    int o;
    z = rot_angle * 131072;
    x = 64'h26DD3B6A;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < CordicStepsDef; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = sat(floor_shift(x + 32768, 16), -16384, 16384);
    s = sat(floor_shift(y + 32768, 16), -16384, 16384);
    omc = 16384 - c;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        v = omc * ax[r] * ax[k];
        if (r == k) v += c * 268435456;
        else begin
          o = 3 - r - k;
          t = s * ax[o] * 16384;
          if (k == (r + 1) % 3) v -= t;
          else v += t;
        end
        coef[r*3+k] = sat(floor_shift(v + 134217728, 28), -32768, 32767);
      end
  endtask

  function automatic vertex_t transform_vertex(vertex_t vin);
    vertex_t r;
    longint p [3];
    longint acc [3];
    p[0] = vin.x; p[1] = vin.y; p[2] = vin.z;
    for (int k = 0; k < 3; k++) begin
      if (!rot_mode)
        acc[k] = floor_shift(coef[k*3]*p[0] + coef[k*3+1]*p[1] + coef[k*3+2]*p[2]
                             + 8192, 14);
      else
        acc[k] = floor_shift(p[k] * scale_q88 + 128, 8);
      acc[k] = sat(acc[k], -32768, 32767);
    end
    r.x = acc[0][15:0];
    r.y = acc[1][15:0];
    r.z = acc[2][15:0];
    r.last = vin.last;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_stall)) begin
      if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        vertex_t v;
        v = pending_vertices.pop_front();
        in_valid <= 1'b1;
        in_vertex_x <= v.x;
        in_vertex_y <= v.y;
        in_vertex_z <= v.z;
        in_last_in <= v.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction on acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_vertices.push_back(transform_vertex({in_vertex_x, in_vertex_y,
                                                    in_vertex_z, in_last_in}));
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        vertex_t e;
        e = expected_vertices.pop_front();
        if (out_out_x !== e.x) report_mismatch("out_x", out_out_x, e.x);
        if (out_out_y !== e.y) report_mismatch("out_y", out_out_y, e.y);
        if (out_out_z !== e.z) report_mismatch("out_z", out_out_z, e.z);
        if (out_last_out !== e.last) report_mismatch("last_out", out_last_out, e.last);
      end
    end
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained;
    while (pending_vertices.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(posedge clk);
    repeat (MatrixSettle) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   rot_mode = data[0];
      REG_AXIS_X: begin ax[0] = $signed(data); rebuild_rotation(); end
      REG_AXIS_Y: begin ax[1] = $signed(data); rebuild_rotation(); end
      REG_AXIS_Z: begin ax[2] = $signed(data); rebuild_rotation(); end
      REG_ANGLE:  begin rot_angle = $signed(data); rebuild_rotation(); end
      REG_SCALE:  scale_q88 = $signed(data);
      default: ;
    endcase
    // matrix rebuild runs after the write
    repeat (MatrixSettle) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(int n);
    vertex_t v;
    for (int i = 0; i < n; i++) begin
      v.x = rand_coord();
      v.y = rand_coord();
      v.z = rand_coord();
      v.last = ($urandom_range(7) == 0);
      pending_vertices.push_back(v);
    end
  endtask

  task automatic unit_axis;
    int pick;
    pick = $urandom_range(3);
    if (pick < 3) begin
      for (int i = 0; i < 3; i++)
        write_reg(reg_idx_t'(REG_AXIS_X + i), (i == pick) ?
                  ($urandom_range(1) ? 16'd16384 : 16'hC000) : 16'd0);
    end else begin
      // roughly diagonal unit axis
      write_reg(REG_AXIS_X, 16'd9459);
      write_reg(REG_AXIS_Y, 16'hDB0D);
      write_reg(REG_AXIS_Z, 16'd9459);
    end
  endtask

  initial begin
    vertex_t v;
    rot_mode = 0;
    ax[0] = 0; ax[1] = 0; ax[2] = 16384;
    rot_angle = 0;
    scale_q88 = 256;
    for (int i = 0; i < 9; i++) coef[i] = (i % 4 == 0) ? 16384 : 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (MatrixSettle) @(posedge clk);

    // directed: identity with field extremes
    for (int b = 0; b < 16; b++) begin
      v.x = 16'sh1 << b; v.y = ~v.x; v.z = -v.x; v.last = b[0];
      pending_vertices.push_back(v);
    end
    v = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1}; pending_vertices.push_back(v);
    v = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0}; pending_vertices.push_back(v);
    wait_drained();

    // angles beyond half pi and the extremes of the range
    write_reg(REG_ANGLE, 16'sd25736);
    queue_random(4); wait_drained();
    write_reg(REG_ANGLE, -16'sd25736);
    queue_random(4); wait_drained();
    write_reg(REG_ANGLE, 16'sh8000);
    queue_random(3); wait_drained();
    // non-unit axis saturates coefficients
    write_reg(REG_AXIS_X, 16'sh7FFF);
    write_reg(REG_AXIS_Y, 16'sh8000);
    queue_random(3); wait_drained();
    write_reg(REG_MODE, 16'd1);
    write_reg(REG_SCALE, 16'sh7FFF);
    queue_random(3); wait_drained();
    write_reg(REG_SCALE, 16'sh8000);
    queue_random(3); wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 16 : 0;
      for (int s = 0; s < 6; s++) begin
        write_reg(REG_MODE, 16'($urandom_range(3) == 0));
        write_reg(REG_SCALE, ($urandom_range(1)) ? 16'($urandom) :
                  16'($signed($urandom_range(1024)) - 512));
        if ($urandom_range(4) == 0) begin
          write_reg(REG_AXIS_X, 16'($urandom));
          write_reg(REG_AXIS_Y, 16'($urandom));
          write_reg(REG_AXIS_Z, 16'($urandom));
        end else unit_axis();
        write_reg(REG_ANGLE, ($urandom_range(5) == 0) ? 16'($urandom) :
                  16'($signed($urandom_range(51472)) - 25736));
        queue_random(100);
        wait_drained();
      end
    end

    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: axis_angle_vertex_rotator.f
rtl/core/aavr_pkg.sv
rtl/core/aavr_matrix.sv
rtl/core/axis_angle_vertex_rotator.sv
tb/axis_angle_vertex_rotator_tb.sv
